/* hdl/afc_pkg.sv */
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the AABB frustum culling block
// Field widths, pipeline array sizes, register indexes and reset rows.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int COORD_W     = 16;  // Q8.8 coordinate
    localparam int COEF_W      = 16;  // Q4.12 coefficient
    localparam int ROW_W       = 64;  // four packed coefficients
    localparam int ROW_COUNT   = 4;   // clip x, y, z, w
    localparam int AXIS_COUNT  = 3;
    localparam int CORNER_COUNT = 8;
    localparam int PLANE_COUNT = 6;
    localparam int FIELD_COUNT = 6;

    localparam int S_TDATA_W = FIELD_COUNT * COORD_W;  // 96
    localparam int M_TDATA_W = 8;

    localparam int PROD_W  = COEF_W + COORD_W;   // 32, exact Q12.20
    localparam int TRANS_W = COEF_W + 8;         // coefficient times 256
    localparam int PAIR_W  = PROD_W + 1;         // sum of two terms
    localparam int CLIP_W  = PROD_W + 2;         // sum of four terms
    localparam int CMP_W   = CLIP_W + 1;         // v + w or w - v

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X = 2'd0,
        CFG_ROW_Y = 2'd1,
        CFG_ROW_Z = 2'd2,
        CFG_ROW_W = 2'd3
    } cfg_index_t;

    localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_W_RESET = 64'h1000_0000_0000_0000;

endpackage

/* hdl/aabb_frustum_cull_top.sv */
// ----------------------------------------------------------------------------
// aabb_frustum_cull_top: clip-space frustum test of an axis-aligned box
// Transforms the eight box corners by a 4x4 matrix and culls the box when
// all corners lie outside one of the six clip planes.
// ----------------------------------------------------------------------------
// Usage: one box (min/max corners, Q8.8) is taken per s_ transfer and one
// result leaves per m_ transfer, in order. The block is a four-stage
// pipeline and accepts a box every cycle unless back-pressure stalls it.
// Its stages are one 16x16 multiply stage, two adder stages that build
// the 34-bit exact clip coordinates, and one stage of plane compares plus
// the AND/OR reduction that also serves as the output register.
// Back-pressure on m_tready stalls only stages that hold data, so bubbles
// close up and nothing is dropped or repeated. The matrix rows come from
// the cfg_ port (Q4.12 coefficients x, y, z, translation from the low
// bits up); write them only while no box is in flight, since stage 1 reads
// them live.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input box channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] min_x, [31:16] min_y, [47:32] min_z,
    // [63:48] max_x, [79:64] max_y, [95:80] max_z
    input  logic [afc_pkg::S_TDATA_W-1:0]       s_tdata,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] inside_res, [7:1] zero
    output logic [afc_pkg::M_TDATA_W-1:0]       m_tdata,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afc_pkg::ROW_W-1:0]           cfg_wdata
);

    // ---------------------------------------------------------------
    // Matrix rows
    // ---------------------------------------------------------------
    logic [afc_pkg::ROW_W-1:0] row_reg [afc_pkg::ROW_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[afc_pkg::CFG_ROW_X] <= afc_pkg::ROW_X_RESET;
            row_reg[afc_pkg::CFG_ROW_Y] <= afc_pkg::ROW_Y_RESET;
            row_reg[afc_pkg::CFG_ROW_Z] <= afc_pkg::ROW_Z_RESET;
            row_reg[afc_pkg::CFG_ROW_W] <= afc_pkg::ROW_W_RESET;
        end else if (cfg_wr_en) begin
            case (afc_pkg::cfg_index_t'(cfg_index))
                afc_pkg::CFG_ROW_X: row_reg[afc_pkg::CFG_ROW_X] <= cfg_wdata;
                afc_pkg::CFG_ROW_Y: row_reg[afc_pkg::CFG_ROW_Y] <= cfg_wdata;
                afc_pkg::CFG_ROW_Z: row_reg[afc_pkg::CFG_ROW_Z] <= cfg_wdata;
                afc_pkg::CFG_ROW_W: row_reg[afc_pkg::CFG_ROW_W] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: a stage advances when it is empty or the next one
    // advances.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic m_tvalid_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !m_tvalid_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg       <= s_tvalid;
            if (adv2) v2_reg       <= v1_reg;
            if (adv3) v3_reg       <= v2_reg;
            if (adv4) m_tvalid_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: per row, coefficient times min and max of each axis,
    // plus the translation term times w = 1.0 (256).
    // Index [row][axis][0 = min, 1 = max].
    // ---------------------------------------------------------------
    logic signed [afc_pkg::PROD_W-1:0]  prod_reg  [afc_pkg::ROW_COUNT][afc_pkg::AXIS_COUNT][2];
    logic signed [afc_pkg::PROD_W-1:0]  prod_next [afc_pkg::ROW_COUNT][afc_pkg::AXIS_COUNT][2];
    logic signed [afc_pkg::TRANS_W-1:0] trans_reg  [afc_pkg::ROW_COUNT];
    logic signed [afc_pkg::TRANS_W-1:0] trans_next [afc_pkg::ROW_COUNT];

    always_comb begin
        logic signed [afc_pkg::COEF_W-1:0]  coef;
        logic signed [afc_pkg::COORD_W-1:0] lo;
        logic signed [afc_pkg::COORD_W-1:0] hi;
        for (int r = 0; r < afc_pkg::ROW_COUNT; r++) begin
            for (int a = 0; a < afc_pkg::AXIS_COUNT; a++) begin
                coef = $signed(row_reg[r][a*afc_pkg::COEF_W +: afc_pkg::COEF_W]);
                lo   = $signed(s_tdata[a*afc_pkg::COORD_W +: afc_pkg::COORD_W]);
                hi   = $signed(s_tdata[(a+afc_pkg::AXIS_COUNT)*afc_pkg::COORD_W
                                       +: afc_pkg::COORD_W]);
                prod_next[r][a][0] = afc_pkg::PROD_W'(coef) * afc_pkg::PROD_W'(lo);
                prod_next[r][a][1] = afc_pkg::PROD_W'(coef) * afc_pkg::PROD_W'(hi);
            end
            trans_next[r] = $signed({row_reg[r][afc_pkg::AXIS_COUNT*afc_pkg::COEF_W
                                               +: afc_pkg::COEF_W], 8'h00});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: x+y partial sums for the four (x, y) choices and
    // z+translation for the two z choices.
    // ---------------------------------------------------------------
    logic signed [afc_pkg::PAIR_W-1:0] xy_reg  [afc_pkg::ROW_COUNT][4];
    logic signed [afc_pkg::PAIR_W-1:0] xy_next [afc_pkg::ROW_COUNT][4];
    logic signed [afc_pkg::PAIR_W-1:0] zt_reg  [afc_pkg::ROW_COUNT][2];
    logic signed [afc_pkg::PAIR_W-1:0] zt_next [afc_pkg::ROW_COUNT][2];

    always_comb begin
        for (int r = 0; r < afc_pkg::ROW_COUNT; r++) begin
            for (int j = 0; j < 4; j++) begin
                // j bit 1 selects max x, bit 0 selects max y
                xy_next[r][j] = afc_pkg::PAIR_W'(prod_reg[r][0][(j >> 1) & 1])
                              + afc_pkg::PAIR_W'(prod_reg[r][1][j & 1]);
            end
            for (int z = 0; z < 2; z++) begin
                zt_next[r][z] = afc_pkg::PAIR_W'(prod_reg[r][2][z])
                              + afc_pkg::PAIR_W'(trans_reg[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            xy_reg <= xy_next;
            zt_reg <= zt_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: exact clip coordinates of every corner.
    // Corner k: bit 2 max x, bit 1 max y, bit 0 max z.
    // ---------------------------------------------------------------
    logic signed [afc_pkg::CLIP_W-1:0] clip_reg  [afc_pkg::CORNER_COUNT][afc_pkg::ROW_COUNT];
    logic signed [afc_pkg::CLIP_W-1:0] clip_next [afc_pkg::CORNER_COUNT][afc_pkg::ROW_COUNT];

    always_comb begin
        for (int k = 0; k < afc_pkg::CORNER_COUNT; k++) begin
            for (int r = 0; r < afc_pkg::ROW_COUNT; r++) begin
                clip_next[k][r] = afc_pkg::CLIP_W'(xy_reg[r][k >> 1])
                                + afc_pkg::CLIP_W'(zt_reg[r][k & 1]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            clip_reg <= clip_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: plane tests. Even plane: v >= -w, odd plane: v <= w.
    // A plane culls when no corner holds it.
    // ---------------------------------------------------------------
    logic inside_next;
    logic inside_reg;

    always_comb begin
        logic signed [afc_pkg::CMP_W-1:0] v;
        logic signed [afc_pkg::CMP_W-1:0] w;
        logic signed [afc_pkg::CMP_W-1:0] margin;
        logic                             any_hold;
        inside_next = 1'b1;
        for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
            any_hold = 1'b0;
            for (int k = 0; k < afc_pkg::CORNER_COUNT; k++) begin
                v = afc_pkg::CMP_W'(clip_reg[k][p >> 1]);
                w = afc_pkg::CMP_W'(clip_reg[k][afc_pkg::CFG_ROW_W]);
                margin = ((p & 1) == 0) ? (v + w) : (w - v);
                if (!margin[afc_pkg::CMP_W-1]) any_hold = 1'b1;
            end
            if (!any_hold) inside_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            inside_reg <= inside_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, inside_reg};

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for aabb_frustum_cull_top
// Boxes go in on the s_ stream and keep/cull verdicts come out on the m_
// stream. An in-bench predictor transforms the eight corners with its own
// copy of the clip matrix and applies the six plane tests at full integer
// width. Every verdict is checked in order against the predicted one. Phases
// step through several matrices, written only while the pipe is empty.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PIPE_DEPTH   = 4;       // transfer-in to m_tvalid
    localparam int  DRAIN_CYCLES = 4 * PIPE_DEPTH;
    localparam int  LONG_HOLD    = 300;     // receiver stall that backs up the pipe
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  Q88_ONE      = 256;     // implicit w = 1.0 of each corner

    // Idle patterns for either side
    localparam int  IDLE_NONE    = 0;
    localparam int  IDLE_RANDOM  = 1;

    // Box as carried on s_tdata, min_x in the low bits
    typedef struct packed {
        logic signed [afc_pkg::COORD_W-1:0] max_z;
        logic signed [afc_pkg::COORD_W-1:0] max_y;
        logic signed [afc_pkg::COORD_W-1:0] max_x;
        logic signed [afc_pkg::COORD_W-1:0] min_z;
        logic signed [afc_pkg::COORD_W-1:0] min_y;
        logic signed [afc_pkg::COORD_W-1:0] min_x;
    } box_t;

    // One predicted verdict, kept with its box for the error report
    typedef struct packed {
        box_t box;
        logic kept;
    } verdict_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [afc_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [afc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_wr_en = 1'b0;
    logic [afc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [afc_pkg::ROW_W-1:0]     cfg_wdata = '0;

    aabb_frustum_cull_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [afc_pkg::ROW_W-1:0] clip_rows [afc_pkg::ROW_COUNT];  // bench copy of the matrix
    box_t             box_queue[$];            // boxes waiting to be sent
    verdict_t         verdicts[$];             // predicted, not yet seen

    int  boxes_queued   = 0;
    int  results_seen   = 0;
    int  kept_count     = 0;
    int  fail_count     = 0;
    int  matrix_count   = 0;
    int  cycle_count    = 0;

    int  tx_mode        = IDLE_RANDOM;
    int  rx_mode        = IDLE_RANDOM;
    int  tx_gap         = 0;
    int  rx_gap         = 0;
    logic rx_hold_req   = 1'b0;
    logic rx_hold_done  = 1'b0;

    // ------------------------------------------------------------------
    // Clock: 20 ns period
    // ------------------------------------------------------------------
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung pipe ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d verdicts seen",
                     cycle_count, results_seen, boxes_queued);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Signed Q4.12 coefficient i of a packed row (x, y, z, translation)
    function automatic longint coef_at(input logic [afc_pkg::ROW_W-1:0] row, input int i);
        return longint'($signed(row[i*afc_pkg::COEF_W +: afc_pkg::COEF_W]));
    endfunction

    // Kept (1) unless all eight clip-space corners fail one plane
    function automatic logic box_inside(input box_t b);
        longint lo [afc_pkg::AXIS_COUNT];
        longint hi [afc_pkg::AXIS_COUNT];
        longint clip [afc_pkg::CORNER_COUNT][afc_pkg::ROW_COUNT];
        longint px, py, pz, v, w;
        logic   any_hold;
        logic   keep;
        lo[0] = longint'($signed(b.min_x));
        lo[1] = longint'($signed(b.min_y));
        lo[2] = longint'($signed(b.min_z));
        hi[0] = longint'($signed(b.max_x));
        hi[1] = longint'($signed(b.max_y));
        hi[2] = longint'($signed(b.max_z));
        // corner k: bit 2 picks x, bit 1 y, bit 0 z from max; no swap of min/max
        for (int k = 0; k < afc_pkg::CORNER_COUNT; k++) begin
            px = k[2] ? hi[0] : lo[0];
            py = k[1] ? hi[1] : lo[1];
            pz = k[0] ? hi[2] : lo[2];
            for (int r = 0; r < afc_pkg::ROW_COUNT; r++)
                clip[k][r] = coef_at(clip_rows[r], 0) * px
                           + coef_at(clip_rows[r], 1) * py
                           + coef_at(clip_rows[r], 2) * pz
                           + coef_at(clip_rows[r], 3) * Q88_ONE;
        end
        // planes: even = axis >= -w, odd = axis <= w; exact, even for w <= 0
        keep = 1'b1;
        for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
            any_hold = 1'b0;
            for (int k = 0; k < afc_pkg::CORNER_COUNT; k++) begin
                v = clip[k][p / 2];
                w = clip[k][afc_pkg::ROW_COUNT-1];
                if ((p % 2 == 0) ? (v >= -w) : (v <= w))
                    any_hold = 1'b1;
            end
            if (!any_hold)
                keep = 1'b0;
        end
        return keep;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input int mode);
        int r;
        if (mode == IDLE_NONE)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [afc_pkg::ROW_W-1:0] pack_row(input int cx, cy, cz, ct);
        return {16'(ct), 16'(cz), 16'(cy), 16'(cx)};
    endfunction

    // Random coefficient within about +-2.0
    function automatic int near_coef();
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    function automatic box_t mk_box(input int min_x, min_y, min_z,
                                    input int max_x, max_y, max_z);
        box_t b;
        b.min_x = 16'(min_x);
        b.min_y = 16'(min_y);
        b.min_z = 16'(min_z);
        b.max_x = 16'(max_x);
        b.max_y = 16'(max_y);
        b.max_z = 16'(max_z);
        return b;
    endfunction

    // One axis: mostly a small span near the view volume, otherwise full
    // 16-bit values, sometimes ordered and sometimes min above max
    task automatic rand_span(output logic signed [afc_pkg::COORD_W-1:0] lo,
                             output logic signed [afc_pkg::COORD_W-1:0] hi);
        int sel, c, e;
        logic signed [afc_pkg::COORD_W-1:0] t;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            c  = int'($urandom_range(0, 1535)) - 768;
            e  = $urandom_range(0, 320);
            lo = 16'(c - e);
            hi = 16'(c + e);
        end else begin
            lo = 16'($urandom);
            hi = 16'($urandom);
            if (sel < 85 && lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
        end
    endtask

    task automatic push_box(input box_t b);
        box_queue = {box_queue, b};
        boxes_queued++;
    endtask

    task automatic push_random(input int count);
        box_t b;
        for (int i = 0; i < count; i++) begin
            rand_span(b.min_x, b.max_x);
            rand_span(b.min_y, b.max_y);
            rand_span(b.min_z, b.max_z);
            push_box(b);
        end
    endtask

    // Sender stays quiet until every verdict is in, then the pipe drains
    task automatic wait_idle();
        while (results_seen < boxes_queued)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write: lands at the edge where cfg_wr_en is seen high
    task automatic write_row(input afc_pkg::cfg_index_t idx,
                             input logic [afc_pkg::ROW_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        clip_rows[idx] = val;
    endtask

    task automatic set_matrix(input logic [afc_pkg::ROW_W-1:0] rx, ry, rz, rw);
        write_row(afc_pkg::CFG_ROW_X, rx);
        write_row(afc_pkg::CFG_ROW_Y, ry);
        write_row(afc_pkg::CFG_ROW_Z, rz);
        write_row(afc_pkg::CFG_ROW_W, rw);
        matrix_count++;
    endtask

    task automatic set_idle(input int tx, input int rx);
        @(posedge aclk);
        tx_mode <= tx;
        rx_mode <= rx;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued boxes, predicts each one at its transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                // box transfers at this edge; matrix is stable while boxes fly
                verdicts = {verdicts,
                            verdict_t'({box_t'(s_tdata), box_inside(box_t'(s_tdata))})};
            end
            if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (box_queue.size() != 0) begin
                s_tdata  <= box_queue.pop_front();
                s_tvalid <= 1'b1;
                tx_gap   <= pick_gap(tx_mode);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random gaps, plus one long hold that backs up the pipe
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (rx_hold_req && !rx_hold_done) begin
            m_tready     <= 1'b0;
            rx_gap       <= LONG_HOLD;
            rx_hold_done <= 1'b1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            rx_gap   <= pick_gap(rx_mode);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each verdict transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t exp_v;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (m_tdata[0])
                kept_count <= kept_count + 1;
            if (verdicts.size() == 0) begin
                $error("unexpected verdict transfer, inside_res actual %0d", m_tdata[0]);
                fail_count <= fail_count + 1;
            end else begin
                exp_v = verdicts.pop_front();
                if (m_tdata[0] !== exp_v.kept) begin
                    $error({"inside_res mismatch: expected %0d, actual %0d",
                            " (box min %0d %0d %0d max %0d %0d %0d)"},
                           exp_v.kept, m_tdata[0],
                           exp_v.box.min_x, exp_v.box.min_y, exp_v.box.min_z,
                           exp_v.box.max_x, exp_v.box.max_y, exp_v.box.max_z);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        clip_rows[afc_pkg::CFG_ROW_X] = afc_pkg::ROW_X_RESET;
        clip_rows[afc_pkg::CFG_ROW_Y] = afc_pkg::ROW_Y_RESET;
        clip_rows[afc_pkg::CFG_ROW_Z] = afc_pkg::ROW_Z_RESET;
        clip_rows[afc_pkg::CFG_ROW_W] = afc_pkg::ROW_W_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // --- Directed boxes on the reset (identity) matrix, w = 1.0 ---
        matrix_count++;
        push_box(mk_box(0, 0, 0, 0, 0, 0));                   // point at origin
        push_box(mk_box(-256, -256, -256, 256, 256, 256));    // the unit cube
        push_box(mk_box(300, 0, 0, 600, 0, 0));               // past x = +w
        push_box(mk_box(-600, 0, 0, -300, 0, 0));             // past x = -w
        push_box(mk_box(0, 300, 0, 0, 600, 0));               // past y = +w
        push_box(mk_box(0, -600, 0, 0, -300, 0));             // past y = -w
        push_box(mk_box(0, 0, 300, 0, 0, 600));               // past z = +w
        push_box(mk_box(0, 0, -600, 0, 0, -300));             // past z = -w
        push_box(mk_box(256, 0, 0, 512, 0, 0));               // touches x = w: kept
        push_box(mk_box(257, 0, 0, 512, 0, 0));               // one LSB past: culled
        push_box(mk_box(-256, -256, -256, -256, -256, -256)); // touches -w corner
        push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        push_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        push_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        push_box(mk_box(256, 256, 256, -256, -256, -256));    // min above max, straddles
        push_box(mk_box(600, 0, 0, 300, 0, 0));               // min above max, outside
        push_box(mk_box(-32768, 1000, -100, 32767, 2000, 100)); // spans x, outside y
        push_box(mk_box(16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA));
        push_box(mk_box(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555));
        wait_idle();

        // --- Camera-like matrix with w = -z, both sides idling ---
        set_matrix(pack_row(4096, 0, 0, 1024), pack_row(0, 6144, 0, -2048),
                   pack_row(0, 0, -4096, -2048), pack_row(0, 0, -4096, 0));
        push_random(200);
        wait_idle();

        // --- Moderate random matrix, sender idles, receiver always ready ---
        set_idle(IDLE_RANDOM, IDLE_NONE);
        set_matrix(pack_row(near_coef(), near_coef(), near_coef(), near_coef()),
                   pack_row(near_coef(), near_coef(), near_coef(), near_coef()),
                   pack_row(near_coef(), near_coef(), near_coef(), near_coef()),
                   pack_row(near_coef(), near_coef(), near_coef(), near_coef()));
        push_random(120);
        wait_idle();

        // --- Full random rows; sender streams while receiver holds off ---
        set_matrix({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
        set_idle(IDLE_NONE, IDLE_RANDOM);
        @(posedge aclk);
        rx_hold_req <= 1'b1;
        push_random(200);
        wait_idle();

        // --- Largest positive coefficients everywhere ---
        set_idle(IDLE_RANDOM, IDLE_RANDOM);
        set_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        push_random(80);
        wait_idle();

        // --- Most negative coefficients everywhere ---
        set_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        push_random(80);
        wait_idle();

        // --- Degenerate: w row zero, planes become x, y, z against zero ---
        set_matrix(afc_pkg::ROW_X_RESET, afc_pkg::ROW_Y_RESET, afc_pkg::ROW_Z_RESET, '0);
        push_box(mk_box(-1, -1, -1, 1, 1, 1));
        push_box(mk_box(1, -1, -1, 2, 1, 1));
        push_random(100);
        wait_idle();

        // --- Negative w: translation -1.0, no corner can pass both sides ---
        set_matrix(afc_pkg::ROW_X_RESET, afc_pkg::ROW_Y_RESET, afc_pkg::ROW_Z_RESET,
                   pack_row(0, 0, 0, -4096));
        push_random(100);
        wait_idle();

        // --- All rows zero: every corner sits on every plane ---
        set_matrix('0, '0, '0, '0);
        push_random(50);
        wait_idle();

        // --- All ones: every coefficient is -1 LSB ---
        set_matrix('1, '1, '1, '1);
        push_random(80);
        wait_idle();

        // --- Reset values written back, no idling on either side ---
        set_idle(IDLE_NONE, IDLE_NONE);
        set_matrix(afc_pkg::ROW_X_RESET, afc_pkg::ROW_Y_RESET, afc_pkg::ROW_Z_RESET,
                   afc_pkg::ROW_W_RESET);
        push_random(100);
        wait_idle();

        // --- Mixed idling to finish ---
        set_idle(IDLE_RANDOM, IDLE_RANDOM);
        push_random(50);
        wait_idle();

        // Let any stray verdict show up before judging
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (verdicts.size() != 0) begin
            $error("%0d predicted verdicts never arrived", verdicts.size());
        end

        $display("Checked %0d boxes across %0d matrices: %0d kept, %0d culled.",
                 results_seen, matrix_count, kept_count, results_seen - kept_count);
        $display({"Covered extreme, zero and degenerate-w matrices, random idling",
                  " and a %0d-cycle output stall."}, LONG_HOLD);
        if (fail_count == 0 && verdicts.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d check(s) failed", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* aabb_frustum_cull_top.f */
hdl/afc_pkg.sv
hdl/aabb_frustum_cull_top.sv
sim/tb.sv
